// File: src/dah_pkg.sv
// ----------------------------------------------------------------------------
// dah_pkg
// Shared types and codes of the d-ary min-heap queue.
// ----------------------------------------------------------------------------
package dah_pkg;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_DEC  = 3'd2,
    OP_INC  = 3'd3,
    OP_DEL  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_UP,
    S_DIV,
    S_PCMP,
    S_UP_END,
    S_LAST,
    S_DN,
    S_SCAN,
    S_DCMP,
    S_DONE
  } state_e;

  localparam int unsigned ArityMin   = 2;
  localparam int unsigned ArityMax   = 8;
  localparam int unsigned ArityReset = 2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [15:0]        vertex_first;
    logic [15:0]        vertex_second;
    logic signed [31:0] weight_value;
    logic [7:0]         slot_index;
  } req_t;

  typedef struct packed {
    logic [15:0]        out_first;
    logic [15:0]        out_second;
    logic signed [31:0] out_weight;
    logic [8:0]         entry_count;
    logic [1:0]         status;
  } rsp_t;

endpackage

// File: src/dah_div.sv
// ----------------------------------------------------------------------------
// dah_div
// Restoring divider of a heap position by the arity, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dah_div #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [3:0]   divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    dvd_q;
  logic [3:0]      rem_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [4:0]      trial;
  logic            fits;

  assign trial = {rem_q, dvd_q[W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[W-2:0], fits};
      rem_q <= fits ? 4'(trial - {1'b0, divisor_i}) : trial[3:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// File: src/d_ary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// d_ary_min_heap_queue
// Min-heap of edge entries with register-set arity, held in one memory.
// ----------------------------------------------------------------------------
// Request channel in_req_i (in_valid_i / in_stall_o) carries one command:
// push, pop, decrease key, increase key or delete at a position. Each
// request gives one response on out_rsp_o (out_valid_o / out_stall_i) with
// the removed entry, the entry count and a status.
// One request is worked at a time. Rejected and unused commands go straight
// to the response. Each sift-up level divides the position by the arity in
// the divider to find the parent and then reads the parent; each sift-down
// level reads the children one at a time through the single memory read
// port.
// The arity register is written on cfg_valid_i (cfg_ready_o is always high);
// it resets to 2, and values outside 2..8 act as the nearest bound.
// Reset empties the heap; the memory is never cleared, since an entry is
// only read after it was written.
// A finished response waits in the output register while out_stall_i is
// high; the next request is already accepted and held back only at its end.
// ----------------------------------------------------------------------------
module d_ary_min_heap_queue #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VERTEX_BITS = 16,
  parameter int unsigned WEIGHT_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dah_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dah_pkg::rsp_t out_rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [3:0]    cfg_data_i
);
  import dah_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > 8) ? CW : 8;
  localparam int unsigned FW = AW + 4;
  localparam int unsigned SW = 34;
  localparam logic signed [SW-1:0] WMax = SW'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] WMin = SW'(-(64'sd1 <<< (WEIGHT_BITS - 1)));

  typedef struct packed {
    logic [VERTEX_BITS-1:0]        first;
    logic [VERTEX_BITS-1:0]        second;
    logic signed [WEIGHT_BITS-1:0] weight;
  } entry_t;

  entry_t mem [CAPACITY];
  entry_t rdata_q;

  state_e state_q, state_d;
  entry_t cur_q, rem_q, best_q;
  logic [AW-1:0] pos_q, bidx_q, kr_q, last_q;
  logic [CW-1:0] count_q;
  logic force_q, down_q, del_q, adj_q, sub_q, bval_q;
  logic signed [31:0] amt_q;
  status_e status_q;
  rsp_t rsp_q;
  logic out_valid_q;
  logic [3:0] arity_q, dk;

  logic mem_re, mem_we, div_start, div_done;
  logic [AW-1:0] mem_ra, mem_wa, div_quo;
  entry_t mem_wd;

  logic acc, slot_ok, is_full, is_empty, take;
  logic [FW-1:0] first_w, last_w, lim_w;
  logic signed [SW-1:0] sum_w, push_w;
  logic signed [WEIGHT_BITS-1:0] adj_wt, push_wt;
  op_e op;

  assign op       = op_e'(in_req_i.opcode);
  assign acc      = in_valid_i && (state_q == S_IDLE);
  assign slot_ok  = XW'(in_req_i.slot_index) < XW'(count_q);
  assign is_full  = count_q >= CW'(CAPACITY);
  assign is_empty = count_q == '0;
  assign dk       = (arity_q < 4'(ArityMin)) ? 4'(ArityMin) :
                    (arity_q > 4'(ArityMax)) ? 4'(ArityMax) : arity_q;

  assign first_w = FW'(pos_q) * FW'(dk) + FW'(1);
  assign last_w  = first_w + FW'(dk) - FW'(1);
  assign lim_w   = FW'(count_q) - FW'(1);

  assign sum_w  = sub_q ? (SW'(rdata_q.weight) - SW'(amt_q))
                        : (SW'(rdata_q.weight) + SW'(amt_q));
  assign adj_wt = (sum_w > WMax) ? WEIGHT_BITS'(WMax) :
                  (sum_w < WMin) ? WEIGHT_BITS'(WMin) : WEIGHT_BITS'(sum_w);
  assign push_w  = SW'(in_req_i.weight_value);
  assign push_wt = (push_w > WMax) ? WEIGHT_BITS'(WMax) :
                   (push_w < WMin) ? WEIGHT_BITS'(WMin) : WEIGHT_BITS'(push_w);

  assign take = !bval_q || (rdata_q.weight < best_q.weight);

  dah_div #(.W(AW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pos_q - 1'b1),
    .divisor_i  (dk),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (op)
            OP_PUSH: state_d = is_full ? S_DONE : S_UP;
            OP_POP:  state_d = is_empty ? S_DONE : S_LOAD;
            OP_DEC, OP_INC, OP_DEL: state_d = slot_ok ? S_LOAD : S_DONE;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_LOAD: state_d = S_UP;
      S_UP:   state_d = (pos_q == '0) ? S_UP_END : S_DIV;
      S_DIV:  state_d = div_done ? S_PCMP : S_DIV;
      S_PCMP: state_d = (force_q || (cur_q.weight < rdata_q.weight)) ? S_UP : S_UP_END;
      S_UP_END: begin
        if (del_q) begin
          state_d = (count_q == CW'(1)) ? S_DONE : S_LAST;
        end else begin
          state_d = down_q ? S_DN : S_DONE;
        end
      end
      S_LAST: state_d = S_DN;
      S_DN:   state_d = (first_w >= FW'(count_q)) ? S_DONE : S_SCAN;
      S_SCAN: state_d = (kr_q == last_q) ? S_DCMP : S_SCAN;
      S_DCMP: state_d = (cur_q.weight > best_q.weight) ? S_DN : S_DONE;
      S_DONE: state_d = (!out_valid_q || !out_stall_i) ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory and divider control
  always_comb begin
    mem_re    = 1'b0;
    mem_ra    = '0;
    mem_we    = 1'b0;
    mem_wa    = pos_q;
    mem_wd    = cur_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (acc && slot_ok && (op == OP_DEC || op == OP_INC || op == OP_DEL)) begin
          mem_re = 1'b1;
          mem_ra = AW'(in_req_i.slot_index);
        end else if (acc && !is_empty && op == OP_POP) begin
          mem_re = 1'b1;
        end
      end
      S_UP: div_start = (pos_q != '0);
      S_DIV: begin
        mem_re = div_done;
        mem_ra = div_quo;
      end
      S_PCMP: begin
        if (force_q || (cur_q.weight < rdata_q.weight)) begin
          mem_we = 1'b1;
          mem_wd = rdata_q;
        end
      end
      S_UP_END: begin
        if (del_q) begin
          mem_re = 1'b1;
          mem_ra = AW'(count_q - 1'b1);
        end else if (!down_q) begin
          mem_we = 1'b1;
        end
      end
      S_DN: begin
        if (first_w >= FW'(count_q)) begin
          mem_we = 1'b1;
        end else begin
          mem_re = 1'b1;
          mem_ra = AW'(first_w);
        end
      end
      S_SCAN: begin
        mem_re = (kr_q != last_q);
        mem_ra = kr_q + 1'b1;
      end
      S_DCMP: begin
        mem_we = 1'b1;
        if (cur_q.weight > best_q.weight) begin
          mem_wd = best_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      arity_q     <= 4'(ArityReset);
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        arity_q <= cfg_data_i;
      end
      if (acc && op == OP_PUSH && !is_full) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == S_UP_END && del_q) begin
        count_q <= count_q - 1'b1;
      end
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          rem_q    <= '0;
          status_q <= ST_OK;
          force_q  <= (op == OP_POP) || (op == OP_DEL);
          del_q    <= (op == OP_POP) || (op == OP_DEL);
          down_q   <= (op == OP_DEC) || (op == OP_INC);
          adj_q    <= (op == OP_DEC) || (op == OP_INC);
          sub_q    <= (op == OP_DEC);
          amt_q    <= in_req_i.weight_value;
          pos_q    <= (op == OP_PUSH) ? AW'(count_q) :
                      (op == OP_POP) ? '0 : AW'(in_req_i.slot_index);
          cur_q.first  <= VERTEX_BITS'(in_req_i.vertex_first);
          cur_q.second <= VERTEX_BITS'(in_req_i.vertex_second);
          cur_q.weight <= push_wt;
          case (op)
            OP_PUSH: if (is_full) status_q <= ST_FULL;
            OP_POP:  if (is_empty) status_q <= ST_EMPTY;
            OP_DEC, OP_INC, OP_DEL: if (!slot_ok) status_q <= ST_BAD;
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        cur_q <= rdata_q;
        if (adj_q) begin
          cur_q.weight <= adj_wt;
        end
      end
      S_PCMP: begin
        if (force_q || (cur_q.weight < rdata_q.weight)) begin
          pos_q <= div_quo;
        end
      end
      S_UP_END: begin
        if (del_q) begin
          rem_q <= cur_q;
          pos_q <= '0;
        end
      end
      S_LAST: cur_q <= rdata_q;
      S_DN: begin
        kr_q   <= AW'(first_w);
        last_q <= (last_w > lim_w) ? AW'(lim_w) : AW'(last_w);
        bval_q <= 1'b0;
      end
      S_SCAN: begin
        if (take) begin
          best_q <= rdata_q;
          bidx_q <= kr_q;
        end
        bval_q <= 1'b1;
        kr_q   <= kr_q + 1'b1;
      end
      S_DCMP: begin
        if (cur_q.weight > best_q.weight) begin
          pos_q <= bidx_q;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          rsp_q.out_first   <= 16'(rem_q.first);
          rsp_q.out_second  <= 16'(rem_q.second);
          rsp_q.out_weight  <= 32'(rem_q.weight);
          rsp_q.entry_count <= 9'(count_q);
          rsp_q.status      <= status_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && (mem_wa == mem_ra)))
    else $error("read and write of one entry in one cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("request accepted without work");
  a_div_only_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside sift up");
`endif

endmodule

// File: sim/tb_d_ary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// tb_d_ary_min_heap_queue
// Self-checking bench for the d-ary min-heap queue: a behavioral heap model
// predicts each response, and directed plus random commands run under
// several arity settings and random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_d_ary_min_heap_queue;
  import dah_pkg::*;

  localparam int unsigned Cap = 256;
  localparam int unsigned WatchLimit = 20000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  req_t  in_req_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  rsp_t  out_rsp_o;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  logic [3:0] cfg_data_i = '0;

  d_ary_min_heap_queue DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  typedef struct {
    logic [15:0] first;
    logic [15:0] second;
    longint      weight;
  } slot_t;

  slot_t       heap_mdl [Cap];
  int unsigned held_mdl;
  logic [3:0]  arity_reg;
  rsp_t        rsp_expected [$];

  int unsigned send_idle_pct, recv_idle_pct;
  bit          hold_recv;
  int          errors = 0;
  int          n_rsp = 0;
  int          watch = 0;
  int          n_sent;

  function automatic int unsigned eff_arity();
    if (arity_reg < ArityMin) return ArityMin;
    if (arity_reg > ArityMax) return ArityMax;
    return arity_reg;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    slot_t t;
    t = heap_mdl[a];
    heap_mdl[a] = heap_mdl[b];
    heap_mdl[b] = t;
  endfunction

  function automatic int unsigned raise_slot(int unsigned pos, bit force_up);
    int unsigned par;
    while (pos > 0 && pos < held_mdl) begin
      par = (pos - 1) / eff_arity();
      if (!force_up && !(heap_mdl[pos].weight < heap_mdl[par].weight)) break;
      swap_slots(pos, par);
      pos = par;
    end
    return pos;
  endfunction

  function automatic void lower_slot(int unsigned pos);
    int unsigned fst, lst, best;
    while (pos < held_mdl) begin
      fst = pos * eff_arity() + 1;
      if (fst >= held_mdl) break;
      lst = fst + eff_arity() - 1;
      if (lst >= held_mdl) lst = held_mdl - 1;
      best = fst;
      for (int unsigned k = fst + 1; k <= lst; k++)
        if (heap_mdl[k].weight < heap_mdl[best].weight) best = k;
      if (!(heap_mdl[pos].weight > heap_mdl[best].weight)) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function automatic slot_t take_min();
    slot_t r;
    r = heap_mdl[0];
    held_mdl--;
    if (held_mdl > 0) begin
      heap_mdl[0] = heap_mdl[held_mdl];
      lower_slot(0);
    end
    return r;
  endfunction

  function automatic rsp_t heap_apply(req_t rq);
    rsp_t  r;
    slot_t rem;
    int unsigned p;
    rem = '{16'd0, 16'd0, 0};
    r = '0;
    r.status = ST_OK;
    case (rq.opcode)
      OP_PUSH: begin
        if (held_mdl >= Cap) r.status = ST_FULL;
        else begin
          heap_mdl[held_mdl] = '{rq.vertex_first, rq.vertex_second, longint'(rq.weight_value)};
          held_mdl++;
          void'(raise_slot(held_mdl - 1, 1'b0));
        end
      end
      OP_POP: begin
        if (held_mdl == 0) r.status = ST_EMPTY;
        else rem = take_min();
      end
      OP_DEC, OP_INC: begin
        if (rq.slot_index >= held_mdl) r.status = ST_BAD;
        else begin
          if (rq.opcode == OP_DEC)
            heap_mdl[rq.slot_index].weight =
              sat32(heap_mdl[rq.slot_index].weight - longint'(rq.weight_value));
          else
            heap_mdl[rq.slot_index].weight =
              sat32(heap_mdl[rq.slot_index].weight + longint'(rq.weight_value));
          p = raise_slot(rq.slot_index, 1'b0);
          lower_slot(p);
        end
      end
      OP_DEL: begin
        if (rq.slot_index >= held_mdl) r.status = ST_BAD;
        else begin
          void'(raise_slot(rq.slot_index, 1'b1));
          rem = take_min();
        end
      end
      default: ;
    endcase
    r.out_first   = rem.first;
    r.out_second  = rem.second;
    r.out_weight  = rem.weight[31:0];
    r.entry_count = held_mdl[8:0];
    return r;
  endfunction

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  // response checker
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_rsp++;
      if (rsp_expected.size() == 0) begin
        $error("response with nothing expected: %p", out_rsp_o);
        errors++;
      end else begin
        e = rsp_expected.pop_front();
        if (out_rsp_o.out_first !== e.out_first) begin
          $error("out_first exp %0d got %0d", e.out_first, out_rsp_o.out_first); errors++;
        end
        if (out_rsp_o.out_second !== e.out_second) begin
          $error("out_second exp %0d got %0d", e.out_second, out_rsp_o.out_second); errors++;
        end
        if (out_rsp_o.out_weight !== e.out_weight) begin
          $error("out_weight exp %0d got %0d", e.out_weight, out_rsp_o.out_weight); errors++;
        end
        if (out_rsp_o.entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, out_rsp_o.entry_count);
          errors++;
        end
        if (out_rsp_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_rsp_o.status); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_recv) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_request(req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= rq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rsp_expected = {rsp_expected, heap_apply(rq)};
    n_sent++;
  endtask

  task automatic send_op(op_e op, logic [15:0] a, logic [15:0] b, int w, logic [7:0] s);
    req_t rq;
    rq.opcode = op;
    rq.vertex_first = a;
    rq.vertex_second = b;
    rq.weight_value = w;
    rq.slot_index = s;
    send_request(rq);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (rsp_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_arity(logic [3:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    arity_reg = v;
  endtask

  function automatic int rand_weight();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return int'($urandom_range(200)) - 100;
    endcase
  endfunction

  function automatic req_t rand_request();
    req_t rq;
    int unsigned k;
    k = $urandom_range(99);
    rq.vertex_first  = 16'($urandom());
    rq.vertex_second = 16'($urandom());
    rq.weight_value  = rand_weight();
    if (k < 40) rq.opcode = OP_PUSH;
    else if (k < 62) rq.opcode = OP_POP;
    else if (k < 76) rq.opcode = OP_DEC;
    else if (k < 88) rq.opcode = OP_INC;
    else if (k < 97) rq.opcode = OP_DEL;
    else rq.opcode = 3'($urandom_range(7, 5));
    if (held_mdl > 0 && $urandom_range(9) != 0) rq.slot_index = 8'($urandom_range(held_mdl - 1));
    else rq.slot_index = 8'($urandom());
    return rq;
  endfunction

  task automatic test_directed();
    send_op(OP_POP, 16'd0, 16'd0, 0, 8'd0);
    send_op(OP_DEC, 16'd0, 16'd0, 1, 8'd0);
    send_op(OP_DEL, 16'd0, 16'd0, 0, 8'd255);
    send_op(OP_PUSH, 16'hffff, 16'h0000, 32'h7fffffff, 8'd0);
    send_op(OP_PUSH, 16'h0000, 16'hffff, 32'h80000000, 8'hff);
    send_op(OP_PUSH, 16'h1234, 16'h5678, 5, 8'd0);
    send_op(OP_PUSH, 16'h1111, 16'h2222, 5, 8'd0);
    send_op(OP_PUSH, 16'h3333, 16'h4444, -7, 8'd0);
    send_op(OP_DEC, 16'd0, 16'd0, 32'h7fffffff, 8'd0);
    send_op(OP_INC, 16'd0, 16'd0, 32'h7fffffff, 8'd4);
    send_op(OP_INC, 16'd0, 16'd0, -50, 8'd3);
    send_op(OP_DEC, 16'd0, 16'd0, -40, 8'd1);
    send_op(OP_INC, 16'd0, 16'd0, 32'h80000000, 8'd2);
    send_op(OP_DEL, 16'd0, 16'd0, 0, 8'd4);
    send_op(OP_DEL, 16'd0, 16'd0, 0, 8'd5);
    send_op(op_e'(3'd5), 16'hffff, 16'hffff, -1, 8'hff);
    send_op(op_e'(3'd7), 16'h0, 16'h0, 0, 8'h0);
    repeat (4) send_op(OP_POP, 16'd0, 16'd0, 0, 8'd0);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_request(rand_request());
  endtask

  task automatic test_fill_backpressure();
    hold_recv = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_recv = 1'b0;
      end
    join_none
    while (held_mdl < Cap)
      send_op(OP_PUSH, 16'($urandom()), 16'($urandom()), $urandom_range(1000), 8'd0);
    send_op(OP_PUSH, 16'h5a5a, 16'ha5a5, 3, 8'd0);
    send_op(OP_DEC, 16'd0, 16'd0, 10, 8'd255);
    send_op(OP_DEL, 16'd0, 16'd0, 0, 8'd255);
    drain();
    while (held_mdl > 0) send_op(OP_POP, 16'd0, 16'd0, 0, 8'd0);
    drain();
  endtask

  initial begin
    n_sent = 0; hold_recv = 1'b0;
    held_mdl = 0; arity_reg = ArityReset;
    send_idle_pct = 19; recv_idle_pct = 63;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_arity(4'd8);
    test_random(150);
    drain();
    send_idle_pct = 63; recv_idle_pct = 19;
    write_arity(4'd0);
    test_random(120);
    drain();
    write_arity(4'd15);
    test_fill_backpressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_arity(4'd3);
    test_random(100);
    drain();
    write_arity(4'd2);
    test_random(80);
    drain();
    $display("ran %0d requests, %0d responses checked, arity 0..15 incl. full heap",
             n_sent, n_rsp);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
